[sv/gbn_pkg.sv]
// Shared types, codes and constants of the go-back-N sender.
package gbn_pkg;

  localparam int SEQ_BITS   = 16;
  localparam int MAX_WINDOW = 63;
  localparam int WIN_BITS   = 6;
  localparam int CNT_BITS   = 32;

  localparam logic [WIN_BITS-1:0] WINDOW_RESET  = WIN_BITS'(1);
  localparam logic [15:0]         TOTAL_RESET   = 16'd20000;
  localparam logic [15:0]         TIMEOUT_RESET = 16'd1500;

  // request kinds
  localparam logic [1:0] KIND_SLOT = 2'd0;
  localparam logic [1:0] KIND_ACK  = 2'd1;
  localparam logic [1:0] KIND_TICK = 2'd2;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_WINDOW  = 2'd0;
  localparam logic [1:0] REG_TOTAL   = 2'd1;
  localparam logic [1:0] REG_TIMEOUT = 2'd2;

  localparam int PADDR_BITS = 4;

  typedef struct packed {
    logic [1:0]          kind;
    logic [SEQ_BITS-1:0] ack_number;
  } cmd_t;

  typedef struct packed {
    logic                send_valid;
    logic [SEQ_BITS-1:0] send_sequence;
    logic                is_retransmit;
    logic                timed_out;
    logic                ack_accepted;
    logic [SEQ_BITS-1:0] base_now;
    logic                transfer_done;
    logic [CNT_BITS-1:0] retransmit_total;
  } result_t;

  // classified request handed from front to back
  typedef struct packed {
    logic                slot;
    logic                ack;
    logic                tick;
    logic [SEQ_BITS-1:0] ack_number;
  } op_t;

  typedef struct packed {
    logic [WIN_BITS-1:0] window_size;
    logic [15:0]         total_count;
    logic [15:0]         timeout_ticks;
  } cfg_t;

endpackage

[sv/gbn_regs.sv]
// APB configuration registers of the go-back-N sender.
module gbn_regs import gbn_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_BITS-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic       wr_en;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[3:2];
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_size   <= WINDOW_RESET;
      cfg.total_count   <= TOTAL_RESET;
      cfg.timeout_ticks <= TIMEOUT_RESET;
    end else if (wr_en) begin
      unique case (idx)
        REG_WINDOW:  cfg.window_size   <= pwdata[WIN_BITS-1:0];
        REG_TOTAL:   cfg.total_count   <= pwdata[15:0];
        REG_TIMEOUT: cfg.timeout_ticks <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_WINDOW:  prdata = {{(32-WIN_BITS){1'b0}}, cfg.window_size};
      REG_TOTAL:   prdata = {16'd0, cfg.total_count};
      REG_TIMEOUT: prdata = {16'd0, cfg.timeout_ticks};
      default:     prdata = 32'd0;
    endcase
  end

endmodule

[sv/gbn_front.sv]
// Front end: accepts requests, decodes the kind and queues them for the back end.
module gbn_front import gbn_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t cmd,
  output logic full,
  output logic op_valid,
  output op_t  op,
  input  logic op_take
);

  op_t        q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_take;
  op_t        decoded;

  assign full     = (count == 2'd2);
  assign op_valid = (count != 2'd0);
  assign op       = q[rd_ptr];
  assign do_push  = push && !full;
  assign do_take  = op_take && op_valid;

  // an unknown kind sets none of the flags and still gives a status result
  always_comb begin
    decoded.slot       = (cmd.kind == KIND_SLOT);
    decoded.ack        = (cmd.kind == KIND_ACK);
    decoded.tick       = (cmd.kind == KIND_TICK);
    decoded.ack_number = cmd.ack_number;
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_take) rd_ptr <= ~rd_ptr;
      count <= count + 2'(do_push) - 2'(do_take);
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 2'd2)
    else $error("front queue count out of range");
`endif

endmodule

[sv/gbn_back.sv]
// Back end: window state update and the result queue.
module gbn_back import gbn_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    op_valid,
  input  op_t     op,
  output logic    op_take,
  output logic    empty,
  output result_t result,
  input  logic    pop
);

  logic [SEQ_BITS-1:0] next_sequence, next_sequence_next;
  logic [SEQ_BITS-1:0] window_base, window_base_next;
  logic [SEQ_BITS-1:0] high_water, high_water_next;
  logic [15:0]         wait_timer, wait_timer_next;
  logic [CNT_BITS-1:0] retransmit_counter, retransmit_counter_next;

  logic [WIN_BITS-1:0] eff_window;
  logic [SEQ_BITS:0]   limit;
  logic                can_send;
  logic [15:0]         tick_limit;
  logic [15:0]         timer_inc;
  logic [SEQ_BITS-1:0] seq_inc;
  result_t             res;

  result_t    oq [2];
  logic       owr, ord;
  logic [1:0] ocount;
  logic       do_pop;

  assign empty   = (ocount == 2'd0);
  assign result  = oq[ord];
  assign do_pop  = pop && !empty;
  assign op_take = op_valid && ((ocount != 2'd2) || do_pop);

  always_comb begin
    if (cfg.window_size == '0) begin
      eff_window = WIN_BITS'(1);
    end else if (cfg.window_size > WIN_BITS'(MAX_WINDOW)) begin
      eff_window = WIN_BITS'(MAX_WINDOW);
    end else begin
      eff_window = cfg.window_size;
    end
  end

  assign limit      = {1'b0, window_base} + (SEQ_BITS+1)'(eff_window);
  assign can_send   = ({1'b0, next_sequence} < limit) && (next_sequence < cfg.total_count);
  assign tick_limit = (cfg.timeout_ticks == 16'd0) ? 16'd1 : cfg.timeout_ticks;
  assign timer_inc  = (wait_timer != 16'hFFFF) ? wait_timer + 16'd1 : wait_timer;
  assign seq_inc    = next_sequence + SEQ_BITS'(1);

  always_comb begin
    next_sequence_next      = next_sequence;
    window_base_next        = window_base;
    high_water_next         = high_water;
    wait_timer_next         = wait_timer;
    retransmit_counter_next = retransmit_counter;
    res                     = '0;

    priority if (op.slot) begin
      if (can_send) begin
        res.send_valid    = 1'b1;
        res.send_sequence = next_sequence;
        if (next_sequence < high_water) begin
          res.is_retransmit = 1'b1;
          if (retransmit_counter != '1) begin
            retransmit_counter_next = retransmit_counter + CNT_BITS'(1);
          end
        end
        next_sequence_next = seq_inc;
        if (seq_inc > high_water) high_water_next = seq_inc;
        wait_timer_next = 16'd0;
      end
    end else if (op.ack) begin
      if ((op.ack_number > window_base) && (op.ack_number <= high_water)) begin
        res.ack_accepted = 1'b1;
        window_base_next = op.ack_number;
        if (next_sequence < op.ack_number) next_sequence_next = op.ack_number;
        wait_timer_next = 16'd0;
      end
    end else if (op.tick) begin
      // timer runs only while the sender is stuck with packets outstanding
      if ((window_base < cfg.total_count) && !can_send) begin
        if (timer_inc >= tick_limit) begin
          res.timed_out      = 1'b1;
          next_sequence_next = window_base;
          wait_timer_next    = 16'd0;
        end else begin
          wait_timer_next = timer_inc;
        end
      end else begin
        wait_timer_next = 16'd0;
      end
    end else begin
    end

    res.base_now         = window_base_next;
    res.transfer_done    = (window_base_next >= cfg.total_count);
    res.retransmit_total = retransmit_counter_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_sequence      <= '0;
      window_base        <= '0;
      high_water         <= '0;
      wait_timer         <= '0;
      retransmit_counter <= '0;
    end else if (op_take) begin
      next_sequence      <= next_sequence_next;
      window_base        <= window_base_next;
      high_water         <= high_water_next;
      wait_timer         <= wait_timer_next;
      retransmit_counter <= retransmit_counter_next;
    end
  end

  always_ff @(posedge clk) begin
    if (op_take) begin
      oq[owr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owr    <= 1'b0;
      ord    <= 1'b0;
      ocount <= 2'd0;
    end else begin
      if (op_take) owr <= ~owr;
      if (do_pop)  ord <= ~ord;
      ocount <= ocount + 2'(op_take) - 2'(do_pop);
    end
  end

`ifndef SYNTHESIS
  a_base_le_hw: assert property (@(posedge clk) disable iff (rst)
    window_base <= high_water)
    else $error("window base above high-water mark");

  a_next_le_hw: assert property (@(posedge clk) disable iff (rst)
    next_sequence <= high_water)
    else $error("next sequence above high-water mark");

  a_rewind: assert property (@(posedge clk) disable iff (rst)
    op_take && res.timed_out |=> next_sequence == window_base)
    else $error("timeout did not rewind to base");

  a_oq_bound: assert property (@(posedge clk) disable iff (rst)
    ocount <= 2'd2)
    else $error("result queue count out of range");
`endif

endmodule

[sv/go_back_n_sender.sv]
// Go-back-N sender top level.
//
// Requests enter on cmd (kind: transmit slot, cumulative ack or timer tick)
// and are taken at a clock edge with push high and full low. Every request
// gives exactly one result on the result port; it waits there while empty
// is low and leaves at an edge with pop high.
// A taken request waits in the front queue until the back end takes it;
// at that edge the back end updates the window and timer state and queues
// the result, which can be popped from then on. The back end takes a
// request only while the result queue has room or a result is popped.
// Throughput: one request a cycle while the result queue does not stall.
// Both sides have a two-entry queue, so a stalled receiver fills the result
// queue, then the request queue, and full rises; no result is lost.
// Registers (APB, byte addresses): 0x0 window_size, 0x4 total_count,
// 0x8 timeout_ticks; write them only while the block holds no request.
// Reset empties both queues, clears sequence, base, high-water mark, timer
// and retransmit count, and loads window 1, total 20000, timeout 1500.
module go_back_n_sender import gbn_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  cmd_t                  cmd,
  output logic                  full,
  output logic                  empty,
  output result_t               result,
  input  logic                  pop,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_BITS-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  cfg_t cfg;
  op_t  op;
  logic op_valid;
  logic op_take;

  gbn_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  gbn_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .cmd      (cmd),
    .full     (full),
    .op_valid (op_valid),
    .op       (op),
    .op_take  (op_take)
  );

  gbn_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .op_valid (op_valid),
    .op       (op),
    .op_take  (op_take),
    .empty    (empty),
    .result   (result),
    .pop      (pop)
  );

endmodule
